### hw/rtl/cps_pkg.sv
// ----------------------------------------------------------------------------
// Closest points between two segments: shared definitions
// Default sizes and the status word that the clamped divider reports.
// ----------------------------------------------------------------------------
`default_nettype none

package cps_pkg;

  // Default coordinate width and number of fraction bits of s and t.
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Status of one clamped ratio n/d, taken at the divider entry.
  typedef struct packed {
    logic neg;  // numerator below zero
    logic gt;   // numerator strictly above the divisor
    logic dz;   // divisor is zero
  } div_flags_t;

endpackage

`default_nettype wire

### hw/rtl/closest_points_two_segments.sv
// ----------------------------------------------------------------------------
// Closest points between two 3D segments
// Fixed-point pipeline: exact dot products, clamped ratios for s and t, and
// the two nearest points, one segment pair per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid, in_ready, seg_a_*, seg_b_* | into block
//   out     | out_valid, out_ready, near_*, param_*| out of block
//
// One transaction is accepted per cycle while the output buffer has space;
// s and t come from two chained restoring dividers of PARAM_FRAC_BITS+3
// stages each (s, then t from the rounded s).
// rst clears every valid bit; payload registers are not reset.
// A stall on the output fills one spare entry, then holds the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_points_two_segments #(
  parameter int COORD_BITS      = cps_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = cps_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_BITS-1:0]  seg_a_start_x,
  input  wire logic signed [COORD_BITS-1:0]  seg_a_start_y,
  input  wire logic signed [COORD_BITS-1:0]  seg_a_start_z,
  input  wire logic signed [COORD_BITS-1:0]  seg_a_end_x,
  input  wire logic signed [COORD_BITS-1:0]  seg_a_end_y,
  input  wire logic signed [COORD_BITS-1:0]  seg_a_end_z,
  input  wire logic signed [COORD_BITS-1:0]  seg_b_start_x,
  input  wire logic signed [COORD_BITS-1:0]  seg_b_start_y,
  input  wire logic signed [COORD_BITS-1:0]  seg_b_start_z,
  input  wire logic signed [COORD_BITS-1:0]  seg_b_end_x,
  input  wire logic signed [COORD_BITS-1:0]  seg_b_end_y,
  input  wire logic signed [COORD_BITS-1:0]  seg_b_end_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_BITS-1:0]       near_a_x,
  output logic signed [COORD_BITS-1:0]       near_a_y,
  output logic signed [COORD_BITS-1:0]       near_a_z,
  output logic signed [COORD_BITS-1:0]       near_b_x,
  output logic signed [COORD_BITS-1:0]       near_b_y,
  output logic signed [COORD_BITS-1:0]       near_b_z,
  output logic [PARAM_FRAC_BITS:0]           param_s,
  output logic [PARAM_FRAC_BITS:0]           param_t
);

  localparam int C   = COORD_BITS;
  localparam int F   = PARAM_FRAC_BITS;
  localparam int QW  = F + 1;
  localparam int DW  = C + 1;
  localparam int PW  = 2 * DW;
  localparam int TW  = PW + 2;
  localparam int MW  = 2 * TW;
  localparam int BSW = TW + QW + 1;
  localparam int NW  = (MW > BSW + 1) ? MW : BSW + 1;
  localparam int OW  = DW + QW + 1;
  localparam int SW1 = 6 * C + 6 * DW + 3 * TW + 2;
  localparam int SW2 = 6 * C + 6 * DW + 3 * QW + 2;
  localparam int ODW = 6 * C + 2 * QW;
  localparam int HALF = 2 ** (F - 1);
  localparam logic [QW-1:0] ONE_Q = {1'b1, {F{1'b0}}};

  logic adv;

  // --------------------------------------------------------------------------
  // Stage 1: direction vectors and start-to-start offset.
  // --------------------------------------------------------------------------
  logic [6*C-1:0]  pts_n;
  logic [6*C-1:0]  ends_n;
  logic [6*DW-1:0] dirs_n;
  logic [3*DW-1:0] rv_n;
  logic            v1;
  logic [6*C-1:0]  pts1;
  logic [6*DW-1:0] dirs1;
  logic [3*DW-1:0] rv1;

  assign pts_n  = {seg_b_start_z, seg_b_start_y, seg_b_start_x,
                   seg_a_start_z, seg_a_start_y, seg_a_start_x};
  assign ends_n = {seg_b_end_z, seg_b_end_y, seg_b_end_x,
                   seg_a_end_z, seg_a_end_y, seg_a_end_x};

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dirs_n[k*DW +: DW] = DW'($signed(ends_n[k*C +: C])) - DW'($signed(pts_n[k*C +: C]));
    end
    for (int k = 0; k < 3; k++) begin
      rv_n[k*DW +: DW] = DW'($signed(pts_n[k*C +: C])) - DW'($signed(pts_n[(k+3)*C +: C]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pts1  <= pts_n;
      dirs1 <= dirs_n;
      rv1   <= rv_n;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: per-axis products of the five dot products.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] d1s [3];
  logic signed [DW-1:0] d2s [3];
  logic signed [DW-1:0] rs  [3];
  logic signed [PW-1:0] pa  [3];
  logic signed [PW-1:0] pe  [3];
  logic signed [PW-1:0] pb  [3];
  logic signed [PW-1:0] pc  [3];
  logic signed [PW-1:0] pf  [3];
  logic                 v2;
  logic [6*C-1:0]       pts2;
  logic [6*DW-1:0]      dirs2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d1s[k] = $signed(dirs1[k*DW +: DW]);
      d2s[k] = $signed(dirs1[(k+3)*DW +: DW]);
      rs[k]  = $signed(rv1[k*DW +: DW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pa[k] <= d1s[k] * d1s[k];
        pe[k] <= d2s[k] * d2s[k];
        pb[k] <= d1s[k] * d2s[k];
        pc[k] <= d1s[k] * rs[k];
        pf[k] <= d2s[k] * rs[k];
      end
      pts2  <= pts1;
      dirs2 <= dirs1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: dot products a, e, b, c, f.
  // --------------------------------------------------------------------------
  logic                 v3;
  logic [6*C-1:0]       pts3;
  logic [6*DW-1:0]      dirs3;
  logic signed [TW-1:0] a3, e3, b3, c3, f3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a3    <= TW'(pa[0]) + TW'(pa[1]) + TW'(pa[2]);
      e3    <= TW'(pe[0]) + TW'(pe[1]) + TW'(pe[2]);
      b3    <= TW'(pb[0]) + TW'(pb[1]) + TW'(pb[2]);
      c3    <= TW'(pc[0]) + TW'(pc[1]) + TW'(pc[2]);
      f3    <= TW'(pf[0]) + TW'(pf[1]) + TW'(pf[2]);
      pts3  <= pts2;
      dirs3 <= dirs2;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4 and 5: wide products a*e, b*b, b*f, c*e.
  // --------------------------------------------------------------------------
  logic signed [MW-1:0] ae5, bb5, bf5, ce5;
  logic                 v4, v5;
  logic [6*C-1:0]       pts4, pts5;
  logic [6*DW-1:0]      dirs4, dirs5;
  logic signed [TW-1:0] a4, b4, c4, e4, f4;
  logic signed [TW-1:0] a5, b5, c5, e5, f5;
  logic                 a0_4, e0_4, a0_5, e0_5;

  cps_mul #(.AW(TW), .BW(TW)) u_mul_ae (.clk(clk), .en(adv), .a(a3), .b(e3), .p(ae5));
  cps_mul #(.AW(TW), .BW(TW)) u_mul_bb (.clk(clk), .en(adv), .a(b3), .b(b3), .p(bb5));
  cps_mul #(.AW(TW), .BW(TW)) u_mul_bf (.clk(clk), .en(adv), .a(b3), .b(f3), .p(bf5));
  cps_mul #(.AW(TW), .BW(TW)) u_mul_ce (.clk(clk), .en(adv), .a(c3), .b(e3), .p(ce5));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pts4  <= pts3;
      dirs4 <= dirs3;
      a4    <= a3;
      b4    <= b3;
      c4    <= c3;
      e4    <= e3;
      f4    <= f3;
      a0_4  <= (a3 == '0);
      e0_4  <= (e3 == '0);
      pts5  <= pts4;
      dirs5 <= dirs4;
      a5    <= a4;
      b5    <= b4;
      c5    <= c4;
      e5    <= e4;
      f5    <= f4;
      a0_5  <= a0_4;
      e0_5  <= e0_4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: numerators and denominators of the three s candidates.
  // --------------------------------------------------------------------------
  logic                 v6;
  logic [6*C-1:0]       pts6;
  logic [6*DW-1:0]      dirs6;
  logic signed [TW-1:0] b6, e6, f6;
  logic                 a0_6, e0_6;
  logic signed [NW-1:0] num6, den6, nlo6, nhi6, adiv6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den6  <= NW'(ae5) - NW'(bb5);
      num6  <= NW'(bf5) - NW'(ce5);
      nlo6  <= -NW'(c5);
      nhi6  <= NW'(b5) - NW'(c5);
      adiv6 <= NW'(a5);
      pts6  <= pts5;
      dirs6 <= dirs5;
      b6    <= b5;
      e6    <= e5;
      f6    <= f5;
      a0_6  <= a0_5;
      e0_6  <= e0_5;
    end
  end

  // --------------------------------------------------------------------------
  // First divider bank: general s, s for t below 0, s for t above 1.
  // --------------------------------------------------------------------------
  logic [SW1-1:0]       side1_in, side1_out;
  logic                 v_o1;
  logic [QW-1:0]        q_gen, q_lo, q_hi;
  cps_pkg::div_flags_t  fl_gen;
  logic [6*C-1:0]       pts_o1;
  logic [6*DW-1:0]      dirs_o1;
  logic signed [TW-1:0] b_o1, e_o1, f_o1;
  logic                 a0_o1, e0_o1;

  assign side1_in = {e0_6, a0_6, f6, e6, b6, dirs6, pts6};
  assign {e0_o1, a0_o1, f_o1, e_o1, b_o1, dirs_o1, pts_o1} = side1_out;

  cps_div #(.NW(NW), .F(F), .SW(SW1)) u_div_gen (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v6),
    .num(num6), .den(den6), .side_in(side1_in),
    .out_valid(v_o1), .quo(q_gen), .flags(fl_gen), .side_out(side1_out)
  );

  cps_div #(.NW(NW), .F(F), .SW(1)) u_div_lo (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v6),
    .num(nlo6), .den(adiv6), .side_in(1'b0),
    .out_valid(), .quo(q_lo), .flags(), .side_out()
  );

  cps_div #(.NW(NW), .F(F), .SW(1)) u_div_hi (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v6),
    .num(nhi6), .den(adiv6), .side_in(1'b0),
    .out_valid(), .quo(q_hi), .flags(), .side_out()
  );

  // --------------------------------------------------------------------------
  // Stages 7 and 8: b*s with the quantized s (zero for parallel segments).
  // --------------------------------------------------------------------------
  logic [QW-1:0]         s_use;
  logic signed [BSW-1:0] bs8;
  logic                  v7, v8;
  logic [6*C-1:0]        pts7, pts8;
  logic [6*DW-1:0]       dirs7, dirs8;
  logic signed [TW-1:0]  e7, f7, e8, f8;
  logic [QW-1:0]         s7, qlo7, qhi7, s8, qlo8, qhi8;
  logic                  a0_7, e0_7, a0_8, e0_8;

  assign s_use = fl_gen.dz ? '0 : q_gen;

  cps_mul #(.AW(TW), .BW(QW + 1)) u_mul_bs (
    .clk(clk), .en(adv), .a(b_o1), .b($signed({1'b0, s_use})), .p(bs8)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (adv) begin
      v7 <= v_o1;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pts7  <= pts_o1;
      dirs7 <= dirs_o1;
      e7    <= e_o1;
      f7    <= f_o1;
      s7    <= s_use;
      qlo7  <= q_lo;
      qhi7  <= q_hi;
      a0_7  <= a0_o1;
      e0_7  <= e0_o1;
      pts8  <= pts7;
      dirs8 <= dirs7;
      e8    <= e7;
      f8    <= f7;
      s8    <= s7;
      qlo8  <= qlo7;
      qhi8  <= qhi7;
      a0_8  <= a0_7;
      e0_8  <= e0_7;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: t numerator b*s + f*2^F and denominator e*2^F.
  // --------------------------------------------------------------------------
  logic                 v9;
  logic [6*C-1:0]       pts9;
  logic [6*DW-1:0]      dirs9;
  logic [QW-1:0]        s9, qlo9, qhi9;
  logic                 a0_9, e0_9;
  logic signed [NW-1:0] tn9, td9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tn9   <= NW'(bs8) + (NW'(f8) <<< F);
      td9   <= NW'(e8) <<< F;
      pts9  <= pts8;
      dirs9 <= dirs8;
      s9    <= s8;
      qlo9  <= qlo8;
      qhi9  <= qhi8;
      a0_9  <= a0_8;
      e0_9  <= e0_8;
    end
  end

  // --------------------------------------------------------------------------
  // Second divider bank: t.
  // --------------------------------------------------------------------------
  logic [SW2-1:0]      side2_in, side2_out;
  logic                v_o2;
  logic [QW-1:0]       q_t;
  cps_pkg::div_flags_t fl_t;
  logic [6*C-1:0]      pts_o2;
  logic [6*DW-1:0]     dirs_o2;
  logic [QW-1:0]       s_o2, qlo_o2, qhi_o2;
  logic                a0_o2, e0_o2;

  assign side2_in = {e0_9, a0_9, qhi9, qlo9, s9, dirs9, pts9};
  assign {e0_o2, a0_o2, qhi_o2, qlo_o2, s_o2, dirs_o2, pts_o2} = side2_out;

  cps_div #(.NW(NW), .F(F), .SW(SW2)) u_div_t (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v9),
    .num(tn9), .den(td9), .side_in(side2_in),
    .out_valid(v_o2), .quo(q_t), .flags(fl_t), .side_out(side2_out)
  );

  // --------------------------------------------------------------------------
  // Stage 10: final s and t, covering degenerate segments and clamped t.
  // --------------------------------------------------------------------------
  logic [QW-1:0]   s_sel, t_sel;
  logic            v10;
  logic [6*C-1:0]  pts10;
  logic [6*DW-1:0] dirs10;
  logic [QW-1:0]   s10, t10;

  always_comb begin
    s_sel = s_o2;
    t_sel = q_t;
    if (a0_o2 && e0_o2) begin
      s_sel = '0;
      t_sel = '0;
    end else if (a0_o2) begin
      s_sel = '0;
    end else if (e0_o2) begin
      s_sel = qlo_o2;
      t_sel = '0;
    end else if (fl_t.neg) begin
      s_sel = qlo_o2;
      t_sel = '0;
    end else if (fl_t.gt) begin
      s_sel = qhi_o2;
      t_sel = ONE_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (adv) begin
      v10 <= v_o2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pts10  <= pts_o2;
      dirs10 <= dirs_o2;
      s10    <= s_sel;
      t10    <= t_sel;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 11: direction times parameter.
  // --------------------------------------------------------------------------
  logic                 v11;
  logic [6*C-1:0]       pts11;
  logic [QW-1:0]        s11, t11;
  logic signed [OW-1:0] prod11 [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (adv) begin
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        prod11[k] <= $signed(dirs10[k*DW +: DW]) * $signed({1'b0, (k < 3) ? s10 : t10});
      end
      pts11 <= pts10;
      s11   <= s10;
      t11   <= t10;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 12: round the offset and add it to the start point.
  // --------------------------------------------------------------------------
  logic                 v12;
  logic [6*C-1:0]       near12;
  logic [QW-1:0]        s12, t12;
  logic signed [OW-1:0] rnd12 [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      rnd12[k] = prod11[k] + OW'(HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
    end else if (adv) begin
      v12 <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        near12[k*C +: C] <= $signed(pts11[k*C +: C]) + C'(rnd12[k] >>> F);
      end
      s12 <= s11;
      t12 <= t11;
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer and pipeline advance.
  // --------------------------------------------------------------------------
  logic [ODW-1:0] dout;

  cps_skid #(.WIDTH(ODW)) u_skid (
    .clk(clk), .rst(rst),
    .push(adv && v12), .din({t12, s12, near12}),
    .space(adv),
    .out_valid(out_valid), .out_ready(out_ready), .dout(dout)
  );

  assign in_ready = adv;

  assign near_a_x = dout[0*C +: C];
  assign near_a_y = dout[1*C +: C];
  assign near_a_z = dout[2*C +: C];
  assign near_b_x = dout[3*C +: C];
  assign near_b_y = dout[4*C +: C];
  assign near_b_z = dout[5*C +: C];
  assign param_s  = dout[6*C +: QW];
  assign param_t  = dout[6*C+QW +: QW];

endmodule

`default_nettype wire

### hw/rtl/cps_mul.sv
// ----------------------------------------------------------------------------
// Split signed multiplier
// Two-stage multiplier: four half-width partial products are registered,
// then shifted and summed into the full product.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_mul #(
  parameter int AW = 36,
  parameter int BW = 36
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic signed [AH-1:0]      ah;
  logic signed [AL:0]        al;
  logic signed [BH-1:0]      bh;
  logic signed [BL:0]        bl;
  logic signed [AH+BH-1:0]   hh;
  logic signed [AH+BL:0]     hl;
  logic signed [AL+BH:0]     lh;
  logic signed [AL+BL+1:0]   ll;
  logic signed [PW-1:0]      sum;

  // The upper halves keep the sign; the lower halves are zero extended.
  assign ah = a[AW-1:AL];
  assign al = {1'b0, a[AL-1:0]};
  assign bh = b[BW-1:BL];
  assign bl = {1'b0, b[BL-1:0]};

  // First stage: partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      hh <= ah * bh;
      hl <= ah * bl;
      lh <= al * bh;
      ll <= al * bl;
    end
  end

  // Second stage: weighted sum of the partial products.
  always_comb begin
    sum = (PW'(hh) <<< (AL + BL)) + (PW'(hl) <<< AL) + (PW'(lh) <<< BL) + PW'(ll);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cps_div.sv
// ----------------------------------------------------------------------------
// Pipelined clamped ratio
// Gives clamp(n/d) in 0..1 with F fraction bits, rounded to nearest with
// ties up: one restoring step per stage, F quotient bits and a round bit.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_div #(
  parameter int NW = 72,
  parameter int F  = 16,
  parameter int SW = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [NW-1:0] num,
  input  wire logic signed [NW-1:0] den,
  input  wire logic [SW-1:0]        side_in,
  output logic                      out_valid,
  output logic [F:0]                quo,
  output cps_pkg::div_flags_t       flags,
  output logic [SW-1:0]             side_out
);

  localparam int NS = F + 1;

  logic                vld  [0:NS];
  logic [NW-1:0]       rem  [0:NS];
  logic [NW-1:0]       dvs  [0:NS];
  logic [NS-1:0]       qb   [0:NS];
  logic                sat0 [0:NS];
  logic                sat1 [0:NS];
  cps_pkg::div_flags_t fl   [0:NS];
  logic [SW-1:0]       side [0:NS];

  logic n_neg;
  logic n_zero;
  logic n_ge;
  logic [F:0] rnd;

  // Entry compares decide the clamped cases.
  assign n_neg  = num[NW-1];
  assign n_zero = (num == '0);
  assign n_ge   = (num >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= num;
      dvs[0]    <= den;
      qb[0]     <= '0;
      sat0[0]   <= n_neg || n_zero;
      sat1[0]   <= n_ge;
      fl[0].neg <= n_neg;
      fl[0].gt  <= n_ge && (num != den);
      fl[0].dz  <= (den == '0);
      side[0]   <= side_in;
    end
  end

  // One restoring step per stage; the last step yields the round bit.
  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [NW-1:0] r2;
    logic          take;

    assign r2   = {rem[k-1][NW-2:0], 1'b0};
    assign take = (r2 >= dvs[k-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= take ? (r2 - dvs[k-1]) : r2;
        dvs[k]  <= dvs[k-1];
        qb[k]   <= {qb[k-1][NS-2:0], take};
        sat0[k] <= sat0[k-1];
        sat1[k] <= sat1[k-1];
        fl[k]   <= fl[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  // Round to nearest: add the bit below the last quotient bit.
  assign rnd = {1'b0, qb[NS][NS-1:1]} + {{F{1'b0}}, qb[NS][0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sat0[NS]) begin
        quo <= '0;
      end else if (sat1[NS]) begin
        quo <= {1'b1, {F{1'b0}}};
      end else begin
        quo <= rnd;
      end
      flags    <= fl[NS];
      side_out <= side[NS];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cps_skid.sv
// ----------------------------------------------------------------------------
// Output buffer
// Output register plus one spare entry, so the pipeline keeps moving while
// a finished transaction waits to be taken, until the spare entry is full.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_skid #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  space,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      dout
);

  logic             spare_valid;
  logic [WIDTH-1:0] spare;
  logic             out_free;

  assign out_free = !out_valid || out_ready;
  assign space    = !spare_valid;

  // Occupancy: the spare entry only fills while the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (out_free) begin
      out_valid   <= spare_valid || push;
      spare_valid <= 1'b0;
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  // Data moves with the occupancy bits.
  always_ff @(posedge clk) begin
    if (out_free) begin
      dout <= spare_valid ? spare : din;
    end else if (push) begin
      spare <= din;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cps_check.sv
// ----------------------------------------------------------------------------
// Port checker for the closest points block
// Watches the top-level ports: reset, buffering, parameter range, stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_check (
  input wire logic                                      clk,
  input wire logic                                      rst,
  input wire logic                                      in_ready,
  input wire logic                                      out_valid,
  input wire logic                                      out_ready,
  input wire logic signed [cps_pkg::COORD_BITS_DEF-1:0] near_a_x,
  input wire logic signed [cps_pkg::COORD_BITS_DEF-1:0] near_b_x,
  input wire logic [cps_pkg::FRAC_BITS_DEF:0]           param_s,
  input wire logic [cps_pkg::FRAC_BITS_DEF:0]           param_t
);

  localparam logic [cps_pkg::FRAC_BITS_DEF:0] ONE_Q = {1'b1, {cps_pkg::FRAC_BITS_DEF{1'b0}}};

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // With nothing waiting at the output, the input must be open.
  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  // Both parameters stay within 0..1.
  a_param_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (param_s <= ONE_Q) && (param_t <= ONE_Q))
    else $error("segment parameter above one");

  // A held transaction keeps its parameters and its x coordinates.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(param_s) && $stable(param_t)
      && $stable(near_a_x) && $stable(near_b_x))
    else $error("output changed during stall");

endmodule

bind closest_points_two_segments cps_check u_cps_check (.*);

`default_nettype wire

### sim/tb_closest_points_two_segments.sv
// ----------------------------------------------------------------------------
// Testbench for the closest points between two segments block
// A table of directed segment pairs, then random pairs of several shapes,
// is streamed through the block, idling at random on both sides. Each result
// is compared field by field with a typed-in row or a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_closest_points_two_segments;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB      = cps_pkg::COORD_BITS_DEF;
  localparam int FB      = cps_pkg::FRAC_BITS_DEF;
  localparam int N_RAND  = 1130;
  localparam int LATENCY = 2 * FB + 19;
  localparam longint ONE = longint'(1) << FB;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CB-1:0] coord_t;

  // One segment pair: P1, Q1, P2, Q2, each x, y, z.
  typedef struct {
    coord_t c[12];
  } seg_pair_t;

  typedef struct {
    coord_t      ax, ay, az, bx, by, bz;
    logic [FB:0] s, t;
  } near_pts_t;

  typedef struct {
    coord_t    c[12];
    bit        known;
    near_pts_t r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  coord_t seg_in[12];
  coord_t near_a_x, near_a_y, near_a_z, near_b_x, near_b_y, near_b_z;
  logic [FB:0] param_s, param_t;

  near_pts_t expected_pts[$];
  int  mismatches = 0;
  int  sent = 0;
  bit  stim_done = 1'b0;
  bit  hold_req = 1'b0;

  initial begin
    foreach (seg_in[i]) seg_in[i] = '0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  closest_points_two_segments u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .seg_a_start_x(seg_in[0]), .seg_a_start_y(seg_in[1]), .seg_a_start_z(seg_in[2]),
    .seg_a_end_x(seg_in[3]), .seg_a_end_y(seg_in[4]), .seg_a_end_z(seg_in[5]),
    .seg_b_start_x(seg_in[6]), .seg_b_start_y(seg_in[7]), .seg_b_start_z(seg_in[8]),
    .seg_b_end_x(seg_in[9]), .seg_b_end_y(seg_in[10]), .seg_b_end_z(seg_in[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .near_a_x(near_a_x), .near_a_y(near_a_y), .near_a_z(near_a_z),
    .near_b_x(near_b_x), .near_b_y(near_b_y), .near_b_z(near_b_z),
    .param_s(param_s), .param_t(param_t)
  );

  // Clamp n/d to 0..1 in Q1.FB, rounded to nearest with ties up; d > 0.
  function automatic longint clamp_ratio(wide_t n, wide_t d);
    wide_t q, rem;
    if (n <= 0) return 0;
    if (n >= d) return ONE;
    q = (n <<< FB) / d;
    rem = (n <<< FB) - q * d;
    if (2 * rem >= d) q = q + 1;
    return longint'(q);
  endfunction

  function automatic wide_t dot3(longint u[3], longint v[3]);
    return wide_t'(u[0]) * wide_t'(v[0]) + wide_t'(u[1]) * wide_t'(v[1])
         + wide_t'(u[2]) * wide_t'(v[2]);
  endfunction

  // Nearest points and parameters for one segment pair.
  function automatic near_pts_t nearest_points(seg_pair_t g);
    longint p1[3], p2[3], d1[3], d2[3], rv[3], pa[3], pb[3];
    longint s, t;
    wide_t a, e, f, b, c, den, tn, td;
    near_pts_t r;
    for (int i = 0; i < 3; i++) begin
      p1[i] = g.c[i];
      p2[i] = g.c[6+i];
      d1[i] = longint'(g.c[3+i]) - p1[i];
      d2[i] = longint'(g.c[9+i]) - p2[i];
      rv[i] = p1[i] - p2[i];
    end
    a = dot3(d1, d1);
    e = dot3(d2, d2);
    f = dot3(d2, rv);
    b = dot3(d1, d2);
    c = dot3(d1, rv);
    s = 0;
    t = 0;
    if (a == 0 && e == 0) begin
      s = 0;
    end else if (a == 0) begin
      t = clamp_ratio(f, e);
    end else if (e == 0) begin
      s = clamp_ratio(-c, a);
    end else begin
      den = a * e - b * b;
      if (den != 0) s = clamp_ratio(b * f - c * e, den);
      tn = b * wide_t'(s) + f * wide_t'(ONE);
      td = e * wide_t'(ONE);
      if (tn < 0) begin
        t = 0;
        s = clamp_ratio(-c, a);
      end else if (tn > td) begin
        t = ONE;
        s = clamp_ratio(b - c, a);
      end else begin
        t = clamp_ratio(tn, td);
      end
    end
    // Rounding to nearest with ties up is a floor after adding one half.
    for (int i = 0; i < 3; i++) begin
      pa[i] = p1[i] + ((d1[i] * s + (ONE >>> 1)) >>> FB);
      pb[i] = p2[i] + ((d2[i] * t + (ONE >>> 1)) >>> FB);
    end
    r.ax = coord_t'(pa[0]); r.ay = coord_t'(pa[1]); r.az = coord_t'(pa[2]);
    r.bx = coord_t'(pb[0]); r.by = coord_t'(pb[1]); r.bz = coord_t'(pb[2]);
    r.s = s[FB:0];
    r.t = t[FB:0];
    return r;
  endfunction

  // Directed pairs; expectations are typed in only where obvious.
  localparam near_pts_t NONE = '{default: 0};
  dir_row_t dir_tab[] = '{
    // Everything at zero.
    '{'{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1'b1, '{0,0,0, 0,0,0, 0,0}},
    // Both segments are points at opposite corners.
    '{'{-32768,-32768,-32768, -32768,-32768,-32768, 32767,32767,32767, 32767,32767,32767},
      1'b1, '{-32768,-32768,-32768, 32767,32767,32767, 0,0}},
    // Second segment is a point above the middle of the first.
    '{'{0,0,0, 100,0,0, 50,7,0, 50,7,0}, 1'b1, '{50,0,0, 50,7,0, 32768,0}},
    // First segment is a point above the middle of the second.
    '{'{50,7,0, 50,7,0, 0,0,0, 100,0,0}, 1'b1, '{50,7,0, 50,0,0, 0,32768}},
    // Parallel and overlapping segments.
    '{'{0,0,0, 100,0,0, 20,5,0, 80,5,0}, 1'b0, NONE},
    // Parallel, pointing opposite ways.
    '{'{0,0,0, 100,100,0, 300,300,9, 200,200,9}, 1'b0, NONE},
    // Crossing segments, interior solution.
    '{'{-100,0,0, 100,0,0, 0,-100,10, 0,100,10}, 1'b0, NONE},
    // Solution needs t below zero.
    '{'{0,0,0, 100,0,0, 50,10,0, 50,200,0}, 1'b0, NONE},
    // Solution needs t above one.
    '{'{0,0,0, 100,0,0, 50,200,0, 50,10,0}, 1'b0, NONE},
    // s clamped at both ends.
    '{'{0,0,0, 10,0,0, 500,-50,3, 500,50,3}, 1'b0, NONE},
    '{'{0,0,0, 10,0,0, -500,-50,3, -500,50,3}, 1'b0, NONE},
    // Full-range diagonals.
    '{'{-32768,-32768,-32768, 32767,32767,32767, 32767,-32768,32767, -32768,32767,-32768},
      1'b0, NONE},
    '{'{32767,-32768,0, -32768,32767,0, -32768,-32768,-32768, 32767,32767,32767},
      1'b0, NONE},
    // Degenerate ones against full-range segments.
    '{'{-32768,32767,-32768, -32768,32767,-32768, -32768,-32768,-32768, 32767,32767,32767},
      1'b0, NONE},
    '{'{32767,-32768,-32768, -32768,32767,32767, 5,5,5, 5,5,5}, 1'b0, NONE},
    // Short segments, rounding ties.
    '{'{0,0,0, 1,0,0, 0,1,1, 1,1,1}, 1'b0, NONE},
    '{'{0,0,0, 3,1,0, 1,3,0, 2,-1,0}, 1'b0, NONE},
    '{'{-1,-1,-1, 1,1,1, 1,-1,0, -1,1,0}, 1'b0, NONE}
  };

  function automatic coord_t rnd_coord(int lim);
    if (lim == 0) return coord_t'($urandom_range(0, 65535));
    return coord_t'($urandom_range(0, 2 * lim) - lim);
  endfunction

  // Random pair: mostly general, plus degenerate, parallel and small shapes.
  function automatic seg_pair_t rnd_pair();
    seg_pair_t g;
    int kind, lim, k;
    kind = $urandom_range(0, 9);
    lim = (kind >= 7) ? 64 : (($urandom_range(0, 1) == 1) ? 0 : 2000);
    foreach (g.c[i]) g.c[i] = rnd_coord(lim);
    case (kind)
      4: for (int i = 0; i < 3; i++) g.c[3+i] = g.c[i];
      5: for (int i = 0; i < 3; i++) g.c[9+i] = g.c[6+i];
      6: for (int i = 0; i < 3; i++) begin
        g.c[3+i] = g.c[i];
        g.c[9+i] = g.c[6+i];
      end
      7, 8: begin
        // Second segment runs along k times the first direction.
        k = $urandom_range(0, 6) - 3;
        for (int i = 0; i < 3; i++)
          g.c[9+i] = g.c[6+i] + coord_t'(k * (g.c[3+i] - g.c[i]));
      end
      default: ;
    endcase
    return g;
  endfunction

  // Offer one transaction, then wait for it to be taken.
  task automatic offer_pair(seg_pair_t g, near_pts_t want);
    foreach (seg_in[i]) seg_in[i] <= g.c[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_pts.push_back(want);
    sent++;
    if (sent == 400) hold_req = 1'b1;
    @(negedge clk);
  endtask

  // Sender: directed table, then random pairs in bursts with gaps.
  initial begin
    seg_pair_t g;
    near_pts_t chk;
    int burst;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_tab[r]) begin
      foreach (g.c[i]) g.c[i] = dir_tab[r].c[i];
      // Rows with a typed-in result are checked against that result.
      if (dir_tab[r].known) begin
        chk = dir_tab[r].r;
      end else begin
        chk = nearest_points(g);
      end
      offer_pair(g, chk);
    end
    burst = 0;
    for (int n = 0; n < N_RAND; n++) begin
      if (burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
        burst = $urandom_range(1, 40);
      end
      g = rnd_pair();
      offer_pair(g, nearest_points(g));
      burst--;
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: stalls on its own changing mask, once for a long stretch.
  initial begin
    logic [7:0] stall_mask;
    int hold_left;
    hold_left = 0;
    stall_mask = '0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if ($urandom_range(0, 31) == 0)
        stall_mask = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !stall_mask[$urandom_range(0, 7)];
      end
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk) begin
    near_pts_t want, got;
    if (!rst && out_valid && out_ready) begin
      got = '{near_a_x, near_a_y, near_a_z, near_b_x, near_b_y, near_b_z, param_s, param_t};
      if (expected_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction on output");
      end else begin
        want = expected_pts.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"exp a=(%0d,%0d,%0d) b=(%0d,%0d,%0d) s=%0d t=%0d, ",
                      "got a=(%0d,%0d,%0d) b=(%0d,%0d,%0d) s=%0d t=%0d"},
                     want.ax, want.ay, want.az, want.bx, want.by, want.bz, want.s, want.t,
                     got.ax, got.ay, got.az, got.bx, got.by, got.bz, got.s, got.t);
        end
      end
    end
  end

  // End of run: drain the expectations, then wait for stray results.
  initial begin
    wait (stim_done);
    while (expected_pts.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_pts.size() == 0)
      $display("closest_points_two_segments: match");
    else
      $display("closest_points_two_segments: mismatch");
    $finish;
  end

  initial begin
    #2ms;
    $display("closest_points_two_segments: mismatch");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/cps_pkg.sv
hw/rtl/cps_mul.sv
hw/rtl/cps_div.sv
hw/rtl/cps_skid.sv
hw/rtl/closest_points_two_segments.sv
hw/rtl/cps_check.sv
sim/tb_closest_points_two_segments.sv
